>>> rtl/vbc_pkg.sv
// Shared types and constants for the victim buffer CAM.
package vbc_pkg;

  localparam int unsigned DEPTH_DEFAULT = 8;
  localparam int unsigned ADDR_BITS_DEFAULT = 32;
  localparam int unsigned FIELD_W = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_CHECK  = 2'd1,
    CMD_DRAIN  = 2'd2,
    CMD_BAD    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_HIT  = 2'd1,
    ST_MISS = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [FIELD_W-1:0] address;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] found_address;
  } result_t;

  // Operation strobes broadcast to every cell, already qualified by the accept.
  typedef struct packed {
    logic insert;
    logic check;
    logic drain;
  } cell_ctrl_t;

endpackage

>>> rtl/vbc_cell.sv
// One slot of the victim buffer: stored address, valid bit and compare.
module vbc_cell
  import vbc_pkg::*;
#(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctrl_t           ctrl,
  input  logic [ADDR_BITS-1:0] key,
  input  logic                 last_cell,
  input  logic                 lower_valid,
  input  logic                 shift_in,
  input  logic                 upper_valid,
  input  logic [ADDR_BITS-1:0] upper_addr,
  output logic                 valid,
  output logic [ADDR_BITS-1:0] addr,
  output logic                 shift_out
);

  logic                 valid_next;
  logic [ADDR_BITS-1:0] addr_next;
  logic                 match;

  assign match     = ctrl.check && valid && (addr == key);
  // Once a lower slot is removed, every slot above it moves down by one.
  assign shift_out = shift_in || match;

  always_comb begin
    valid_next = valid;
    addr_next  = addr;
    if (ctrl.insert) begin
      // First empty slot takes the address; a full buffer overwrites the last slot.
      if ((!valid && lower_valid) || (last_cell && valid)) begin
        valid_next = 1'b1;
        addr_next  = key;
      end
    end else if (shift_out) begin
      valid_next = upper_valid;
      addr_next  = upper_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
  end

endmodule

>>> rtl/victim_buffer_cam.sv
// Top level of the victim buffer CAM: a chain of slot cells and the result register.
//
//   channel  direction  beat type  handshake
//   item     in         item_t     item_valid / item_stall
//   result   out        result_t   result_valid / result_stall
//
// All slots compare and shift together on each command, and the result appears in the
// output register on the next cycle. One command is accepted per cycle while the result
// side keeps up; the compare and removal chain through the cells sets the cycle time.
// Reset clears all valid bits.
// A stalled result holds the register and stalls the item side.
module victim_buffer_cam
  import vbc_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEFAULT,
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic                 accept;
  cell_ctrl_t           ctrl;
  logic [ADDR_BITS-1:0] key;
  logic [DEPTH-1:0]     cell_valid;
  logic [ADDR_BITS-1:0] cell_addr [DEPTH];
  logic [DEPTH:0]       shift_chain;
  result_t              result_next;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign key        = ADDR_BITS'(item.address);

  assign ctrl.insert = accept && (cmd_t'(item.command) == CMD_INSERT);
  assign ctrl.check  = accept && (cmd_t'(item.command) == CMD_CHECK);
  assign ctrl.drain  = accept && (cmd_t'(item.command) == CMD_DRAIN);

  // A drain removes slot 0, so the chain starts out shifting.
  assign shift_chain[0] = ctrl.drain;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 lower_valid;
    logic                 upper_valid;
    logic [ADDR_BITS-1:0] upper_addr;

    if (i == 0) begin : g_first
      assign lower_valid = 1'b1;
    end else begin : g_inner_lo
      assign lower_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_valid = 1'b0;
      assign upper_addr  = '0;
    end else begin : g_inner_hi
      assign upper_valid = cell_valid[i+1];
      assign upper_addr  = cell_addr[i+1];
    end

    vbc_cell #(
      .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key        (key),
      .last_cell  (i == DEPTH - 1),
      .lower_valid(lower_valid),
      .shift_in   (shift_chain[i]),
      .upper_valid(upper_valid),
      .upper_addr (upper_addr),
      .valid      (cell_valid[i]),
      .addr       (cell_addr[i]),
      .shift_out  (shift_chain[i+1])
    );
  end

  always_comb begin
    result_next.status        = ST_DONE;
    result_next.found_address = '0;
    case (cmd_t'(item.command))
      CMD_INSERT: result_next.status = ST_DONE;
      CMD_CHECK: begin
        // With no drain, the chain end is set only by a matching slot.
        if (shift_chain[DEPTH]) begin
          result_next.status        = ST_HIT;
          result_next.found_address = FIELD_W'(key);
        end else begin
          result_next.status = ST_MISS;
        end
      end
      CMD_DRAIN: result_next.status = ST_DONE;
      default:   result_next.status = ST_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!item_stall) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // Valid slots always form a prefix starting at slot 0.
  assert property (@(posedge clk) disable iff (rst)
    (cell_valid & ~{cell_valid[DEPTH-2:0], 1'b1}) == '0)
    else $error("victim buffer valid slots are not compacted");

  assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |=> cell_valid[0])
    else $error("insert left slot 0 empty");

  assert property (@(posedge clk) disable iff (rst)
    (ctrl.drain && cell_valid[0]) |=>
      ($countones(cell_valid) + 1 == $past($countones(cell_valid))))
    else $error("drain did not remove exactly one entry");

  assert property (@(posedge clk) disable iff (rst)
    (ctrl.check && shift_chain[DEPTH]) |=>
      ($countones(cell_valid) + 1 == $past($countones(cell_valid))))
    else $error("hit did not remove exactly one entry");

endmodule

>>> verif/victim_buffer_cam_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the victim buffer CAM: a directed table, then weighted random traffic.
module victim_buffer_cam_test;
  import vbc_pkg::*;

  localparam int unsigned SLOTS = DEPTH_DEFAULT;
  localparam int RANDOM_BEATS = 1200;
  localparam int QUIET_TAIL = 150;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    item_t   beat;
    bit      typed;
    result_t want;
  } line_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  item_t   item = '0;
  logic    result_stall = 1'b0;
  logic    item_stall;
  logic    result_valid;
  result_t result;

  victim_buffer_cam uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Buffered line addresses, oldest first, exactly as the block should hold them.
  logic [FIELD_W-1:0] buffered_lines[$];
  logic [FIELD_W-1:0] hot_lines[16];
  result_t            replies_due[$];
  line_row_t          line_table[$];
  int                 mismatch_count = 0;
  int unsigned        cycle_count = 0;
  int                 stall_left = 0;
  bit                 rx_quiet = 1'b0;
  bit                 rx_calm = 1'b0;

  task automatic flag_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic result_t apply_to_buffer(item_t b);
    result_t r;
    int      hit_at;
    r.status = ST_DONE;
    r.found_address = '0;
    hit_at = -1;
    case (b.command)
      CMD_INSERT: begin
        if (buffered_lines.size() < SLOTS) buffered_lines.push_back(b.address);
        else buffered_lines[SLOTS-1] = b.address;
      end
      CMD_CHECK: begin
        // The oldest matching slot wins when an address is held twice.
        foreach (buffered_lines[i])
          if (hit_at < 0 && buffered_lines[i] == b.address) hit_at = i;
        if (hit_at < 0) begin
          r.status = ST_MISS;
        end else begin
          r.status = ST_HIT;
          r.found_address = b.address;
          buffered_lines.delete(hit_at);
        end
      end
      CMD_DRAIN: begin
        if (buffered_lines.size() != 0) buffered_lines.delete(0);
      end
      default: begin
        r.status = ST_BAD;
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(cmd_t c, logic [FIELD_W-1:0] a, bit typed,
                                  status_t s, logic [FIELD_W-1:0] f);
    line_row_t row;
    row.beat.command = c;
    row.beat.address = a;
    row.typed = typed;
    row.want.status = s;
    row.want.found_address = f;
    line_table.push_back(row);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_line(bit for_insert);
    int roll;
    roll = $urandom_range(0, 9);
    if (buffered_lines.size() != 0 && roll < (for_insert ? 2 : 6))
      return buffered_lines[$urandom_range(0, buffered_lines.size() - 1)];
    if (roll < (for_insert ? 5 : 8)) return hot_lines[$urandom_range(0, 15)];
    if (roll == 9) begin
      if ($urandom_range(0, 1) == 1) return {FIELD_W{1'b1}};
      return '0;
    end
    return $urandom();
  endfunction

  // lean 0 fills the buffer, 1 keeps it level, 2 empties it.
  function automatic item_t pick_beat(int lean);
    item_t b;
    int    roll;
    int    ins_cut;
    int    chk_cut;
    int    drn_cut;
    case (lean)
      0: begin
        ins_cut = 55; chk_cut = 80; drn_cut = 93;
      end
      1: begin
        ins_cut = 40; chk_cut = 75; drn_cut = 92;
      end
      default: begin
        ins_cut = 25; chk_cut = 70; drn_cut = 92;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_cut) begin
      b.command = CMD_INSERT;
      b.address = pick_line(1'b1);
    end else if (roll < chk_cut) begin
      b.command = CMD_CHECK;
      b.address = pick_line(1'b0);
    end else if (roll < drn_cut) begin
      b.command = CMD_DRAIN;
      b.address = $urandom();
    end else begin
      b.command = CMD_BAD;
      b.address = $urandom();
    end
    return b;
  endfunction

  task automatic push_item(item_t b, bit typed, result_t want);
    result_t guess;
    item <= b;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    guess = apply_to_buffer(b);
    if (typed) replies_due.push_back(want);
    else replies_due.push_back(guess);
  endtask

  task automatic maybe_pause(bit allow);
    int gap;
    if (allow && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_replies();
    item_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  always @(posedge clk) begin : receive_side
    result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("victim_buffer_cam_test: errors");
      $finish;
    end else begin
      if (!rst && result_valid && !result_stall) begin
        if (replies_due.size() == 0) begin
          flag_mismatch($sformatf("unrequested beat status %0d address %h",
                                  result.status, result.found_address));
        end else begin
          want = replies_due.pop_front();
          if (result.status !== want.status)
            flag_mismatch($sformatf("status %0d, wanted %0d", result.status, want.status));
          if (result.found_address !== want.found_address)
            flag_mismatch($sformatf("found_address %h, wanted %h",
                                    result.found_address, want.found_address));
        end
      end
      if (rx_quiet || rx_calm) begin
        result_stall <= 1'b0;
      end else if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  initial begin : stimulus
    result_t none;
    int      lean;
    int      n;
    bit      tx_calm;
    none = '0;
    lean = 1;
    tx_calm = 1'b0;
    foreach (hot_lines[i]) hot_lines[i] = $urandom();

    add_row(CMD_DRAIN,  32'h0000_0000, 1'b1, ST_DONE, 32'h0000_0000);
    add_row(CMD_CHECK,  32'h0000_0000, 1'b1, ST_MISS, 32'h0000_0000);
    add_row(CMD_BAD,    32'hffff_ffff, 1'b1, ST_BAD,  32'h0000_0000);
    add_row(CMD_INSERT, 32'h0000_0000, 1'b1, ST_DONE, 32'h0000_0000);
    add_row(CMD_INSERT, 32'hffff_ffff, 1'b1, ST_DONE, 32'h0000_0000);
    // A second copy of zero: only the oldest one goes on the first hit.
    add_row(CMD_INSERT, 32'h0000_0000, 1'b1, ST_DONE, 32'h0000_0000);
    add_row(CMD_CHECK,  32'h0000_0000, 1'b1, ST_HIT,  32'h0000_0000);
    add_row(CMD_CHECK,  32'hffff_ffff, 1'b1, ST_HIT,  32'hffff_ffff);
    add_row(CMD_CHECK,  32'h0000_0000, 1'b1, ST_HIT,  32'h0000_0000);
    add_row(CMD_CHECK,  32'h0000_0000, 1'b1, ST_MISS, 32'h0000_0000);
    for (n = 1; n <= SLOTS; n++)
      add_row(CMD_INSERT, 32'ha5a5_0000 + n, 1'b1, ST_DONE, 32'h0000_0000);
    // Full now, so this one lands on top of the youngest slot.
    add_row(CMD_INSERT, 32'h5a5a_ffff, 1'b1, ST_DONE, 32'h0000_0000);
    add_row(CMD_CHECK,  32'ha5a5_0000 + SLOTS, 1'b0, ST_DONE, 32'h0000_0000);
    add_row(CMD_CHECK,  32'h5a5a_ffff, 1'b0, ST_DONE, 32'h0000_0000);
    add_row(CMD_CHECK,  32'ha5a5_0003, 1'b0, ST_DONE, 32'h0000_0000);
    add_row(CMD_DRAIN,  32'h0000_0000, 1'b1, ST_DONE, 32'h0000_0000);
    add_row(CMD_BAD,    32'h0000_0000, 1'b1, ST_BAD,  32'h0000_0000);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (line_table[i]) begin
      push_item(line_table[i].beat, line_table[i].typed, line_table[i].want);
      maybe_pause(1'b1);
    end
    wait_for_replies();

    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 60 == 0) begin
        lean = $urandom_range(0, 2);
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm <= ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_BEATS / 2) wait_for_replies();
      if (n == RANDOM_BEATS - QUIET_TAIL) rx_quiet <= 1'b1;
      push_item(pick_beat(lean), 1'b0, none);
      maybe_pause(n < RANDOM_BEATS - QUIET_TAIL && !tx_calm);
    end

    item_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("victim_buffer_cam_test: clean");
    end else begin
      $display("victim_buffer_cam_test: errors");
    end
    $finish;
  end

endmodule
